>>> src/sbm_pkg.sv
// Shared types, constants and tables for the spherical backward map.
// No dependencies; every other file imports this package.
package sbm_pkg;

    // Fixed-point constants (Q.28 angles)
    localparam logic [44:0] HALF_PI_Q28 = 45'd421657428;
    localparam logic signed [31:0] CORDIC_GAIN_Q28 = 32'sd163008218;
    // 8192 full turns: lifts any scaled angle to a non-negative value
    localparam logic signed [45:0] ANGLE_LIFT = 46'sd13816870600704;

    localparam int RED_STEPS = 16;     // quotient bits of angle / (pi/2)
    localparam int DIV_STEPS = 25;     // one overflow bit plus 24 quotient bits
    localparam int NUM_W     = 46;     // X, Y, Z in Q.24
    localparam int DEN_W     = 45;
    localparam int REM_W     = 70;     // divider partial remainder
    localparam int CFG_IDX_W = 3;

    localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] OUT_MIN = 24'sh800000;

    localparam logic signed [31:0] ATAN_Q28 [24] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAIR0     = 3'd0,
        REG_PAIR1     = 3'd1,
        REG_PAIR2     = 3'd2,
        REG_PAIR3     = 3'd3,
        REG_LAST_INV  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [44:0] rem;
        logic [1:0]  q;
    } t_red_lane;
    typedef t_red_lane [1:0] t_red_pair;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [1:0]         q;
    } t_cor_lane;
    typedef t_cor_lane [1:0] t_cor_pair;

    typedef struct packed {
        logic [REM_W-1:0]     rem_x;
        logic [REM_W-1:0]     rem_y;
        logic [DIV_STEPS-1:0] q_x;
        logic [DIV_STEPS-1:0] q_y;
        logic [DEN_W-1:0]     den;
        logic                 neg_x;
        logic                 neg_y;
        logic                 front;
    } t_div_word;

    typedef struct packed {
        logic signed [23:0] src_x;
        logic signed [23:0] src_y;
        logic               in_front;
        logic               clipped;
    } t_res;

endpackage

>>> src/sbm_if.sv
// Handshake channels of the spherical backward map: input, result, config.
// Depends on sbm_pkg.
interface sbm_in_if import sbm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [19:0] pano_u;
    logic signed [19:0] pano_v;
    modport source (output valid, pano_u, pano_v, input ready);
    modport sink   (input valid, pano_u, pano_v, output ready);
endinterface

interface sbm_out_if import sbm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [23:0] src_x;
    logic signed [23:0] src_y;
    logic               in_front;
    logic               clipped;
    modport source (output valid, src_x, src_y, in_front, clipped, input ready);
    modport sink   (input valid, src_x, src_y, in_front, clipped, output ready);
endinterface

interface sbm_cfg_if import sbm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          data;
    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

>>> src/sbm_red_cell.sv
// One restoring step of the angle reduction by pi/2, both angles side by side.
// Depends on sbm_pkg.
module sbm_red_cell import sbm_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_vld,
    input  t_red_pair i_w,
    output logic      o_vld,
    output t_red_pair o_w
);
    localparam logic [44:0] SUB = HALF_PI_Q28 << STEP;

    t_red_pair n_w;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (i_w[l].rem >= SUB) begin
                n_w[l].rem = i_w[l].rem - SUB;
                n_w[l].q   = {i_w[l].q[0], 1'b1};
            end else begin
                n_w[l].rem = i_w[l].rem;
                n_w[l].q   = {i_w[l].q[0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_w <= n_w;
        end
    end
endmodule

>>> src/sbm_cordic_cell.sv
// One rotation-mode CORDIC iteration, both angles side by side.
// Depends on sbm_pkg.
module sbm_cordic_cell import sbm_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_vld,
    input  t_cor_pair i_w,
    output logic      o_vld,
    output t_cor_pair o_w
);
    t_cor_pair n_w;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_w[l].q = i_w[l].q;
            // zero residual rotates forward
            if (!i_w[l].z[31]) begin
                n_w[l].x = i_w[l].x - (i_w[l].y >>> STAGE);
                n_w[l].y = i_w[l].y + (i_w[l].x >>> STAGE);
                n_w[l].z = i_w[l].z - ATAN_Q28[STAGE];
            end else begin
                n_w[l].x = i_w[l].x + (i_w[l].y >>> STAGE);
                n_w[l].y = i_w[l].y - (i_w[l].x >>> STAGE);
                n_w[l].z = i_w[l].z + ATAN_Q28[STAGE];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_w <= n_w;
        end
    end
endmodule

>>> src/sbm_div_cell.sv
// One restoring division step for both projected coordinates over the depth.
// Depends on sbm_pkg.
module sbm_div_cell import sbm_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_vld,
    input  t_div_word i_w,
    output logic      o_vld,
    output t_div_word o_w
);
    logic [REM_W-1:0] w_den;
    t_div_word        n_w;

    assign w_den = REM_W'(i_w.den) << SHIFT;

    always_comb begin
        n_w = i_w;
        if (i_w.rem_x >= w_den) begin
            n_w.rem_x = i_w.rem_x - w_den;
            n_w.q_x   = {i_w.q_x[DIV_STEPS-2:0], 1'b1};
        end else begin
            n_w.q_x   = {i_w.q_x[DIV_STEPS-2:0], 1'b0};
        end
        if (i_w.rem_y >= w_den) begin
            n_w.rem_y = i_w.rem_y - w_den;
            n_w.q_y   = {i_w.q_y[DIV_STEPS-2:0], 1'b1};
        end else begin
            n_w.q_y   = {i_w.q_y[DIV_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_w <= n_w;
        end
    end
endmodule

>>> src/spherical_backward_map.sv
// Spherical backward map: panorama (u, v) to source-image (x, y).
// One word per cycle while the output is ready; back-pressure stalls the chain.
// Chain: angle multiply and lift, 16 reduction cells, ANGLE_STAGES CORDIC cells,
// fold, ray, matrix, sums, set-up, 25 divider cells, two-entry output buffer.
// Synchronous active-low reset clears all valids and the configuration to zero.
// Depends on sbm_pkg, sbm_if, sbm_red_cell, sbm_cordic_cell, sbm_div_cell.
module spherical_backward_map import sbm_pkg::*; #(
    parameter int ANGLE_STAGES  = 16,
    parameter int OUT_FRAC_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sbm_in_if.sink        i_in,
    sbm_out_if.source     o_out,
    sbm_cfg_if.sink       i_cfg
);
    localparam logic signed [23:0] BEHIND = -(24'sd1 <<< OUT_FRAC_BITS);

    // configuration
    logic [63:0]        r_cfg [5];
    logic signed [31:0] w_coef [9];
    logic [31:0]        w_inv;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_cfg[i] <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                REG_PAIR0:    r_cfg[0] <= i_cfg.data;
                REG_PAIR1:    r_cfg[1] <= i_cfg.data;
                REG_PAIR2:    r_cfg[2] <= i_cfg.data;
                REG_PAIR3:    r_cfg[3] <= i_cfg.data;
                REG_LAST_INV: r_cfg[4] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_coef[k] = (k % 2 == 1) ? r_cfg[k/2][63:32] : r_cfg[k/2][31:0];
        end
    end
    assign w_inv = r_cfg[4][63:32];

    // pipeline advances whenever the skid entry is free
    logic r_sk_vld;
    logic w_en;
    assign w_en = !r_sk_vld;
    assign i_in.ready = w_en;

    // angle products, Q.36
    logic signed [32:0] w_inv_s;
    logic signed [52:0] w_u, w_v;
    logic               r_s1_vld;
    logic signed [52:0] r_s1_pu, r_s1_pv;

    assign w_inv_s = $signed({1'b0, w_inv});
    assign w_u = 53'(i_in.pano_u);
    assign w_v = 53'(i_in.pano_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pu <= w_u * 53'(w_inv_s);
            r_s1_pv <= w_v * 53'(w_inv_s);
        end
    end

    // floor to Q.28 and lift by whole turns
    logic signed [45:0] w_lift_u, w_lift_v;
    logic               w_red_vld [RED_STEPS+1];
    t_red_pair          w_red     [RED_STEPS+1];
    logic               r_s2_vld;
    t_red_pair          r_s2;

    assign w_lift_u = {r_s1_pu[52], r_s1_pu[52:8]} + ANGLE_LIFT;
    assign w_lift_v = {r_s1_pv[52], r_s1_pv[52:8]} + ANGLE_LIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2[0].rem <= w_lift_u[44:0];
            r_s2[0].q   <= 2'd0;
            r_s2[1].rem <= w_lift_v[44:0];
            r_s2[1].q   <= 2'd0;
        end
    end

    assign w_red_vld[0] = r_s2_vld;
    assign w_red[0]     = r_s2;

    for (genvar g = 0; g < RED_STEPS; g++) begin : g_red
        sbm_red_cell #(.STEP(RED_STEPS - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_red_vld[g]),
            .i_w     (w_red[g]),
            .o_vld   (w_red_vld[g+1]),
            .o_w     (w_red[g+1])
        );
    end

    // CORDIC chain
    logic      w_cor_vld [ANGLE_STAGES+1];
    t_cor_pair w_cor     [ANGLE_STAGES+1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_cor[0][l].x = CORDIC_GAIN_Q28;
            w_cor[0][l].y = '0;
            w_cor[0][l].z = $signed(32'(w_red[RED_STEPS][l].rem));
            w_cor[0][l].q = w_red[RED_STEPS][l].q;
        end
    end
    assign w_cor_vld[0] = w_red_vld[RED_STEPS];

    for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cor
        sbm_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_cor_vld[g]),
            .i_w     (w_cor[g]),
            .o_vld   (w_cor_vld[g+1]),
            .o_w     (w_cor[g+1])
        );
    end

    // quadrant fold: lane 0 gives (cos a, sin a), lane 1 (cos b, sin b)
    logic signed [31:0] w_cos [2];
    logic signed [31:0] w_sin [2];
    logic               r_s3_vld;
    logic signed [31:0] r_s3_cos [2];
    logic signed [31:0] r_s3_sin [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            case (w_cor[ANGLE_STAGES][l].q)
                2'd0: begin
                    w_cos[l] = w_cor[ANGLE_STAGES][l].x;
                    w_sin[l] = w_cor[ANGLE_STAGES][l].y;
                end
                2'd1: begin
                    w_cos[l] = -w_cor[ANGLE_STAGES][l].y;
                    w_sin[l] = w_cor[ANGLE_STAGES][l].x;
                end
                2'd2: begin
                    w_cos[l] = -w_cor[ANGLE_STAGES][l].x;
                    w_sin[l] = -w_cor[ANGLE_STAGES][l].y;
                end
                default: begin
                    w_cos[l] = w_cor[ANGLE_STAGES][l].y;
                    w_sin[l] = -w_cor[ANGLE_STAGES][l].x;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= w_cor_vld[ANGLE_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_cos <= w_cos;
            r_s3_sin <= w_sin;
        end
    end

    // ray products
    logic               r_s4_vld;
    logic signed [63:0] r_s4_sbsa, r_s4_sbca;
    logic signed [31:0] r_s4_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (w_en) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_sbsa <= 64'(r_s3_sin[1]) * 64'(r_s3_sin[0]);
            r_s4_sbca <= 64'(r_s3_sin[1]) * 64'(r_s3_cos[0]);
            r_s4_ry   <= -r_s3_cos[1];
        end
    end

    // matrix products, Q.44
    logic signed [31:0] w_ray [3];
    logic               r_s5_vld;
    logic signed [63:0] r_s5_prod [9];

    assign w_ray[0] = r_s4_sbsa[59:28];
    assign w_ray[1] = r_s4_ry;
    assign w_ray[2] = r_s4_sbca[59:28];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (w_en) begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_s5_prod[k] <= 64'(w_coef[k]) * 64'(w_ray[k%3]);
            end
        end
    end

    // row sums, floor to Q.24
    logic signed [65:0]      w_sum [3];
    logic                    r_s6_vld;
    logic signed [NUM_W-1:0] r_s6_acc [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_sum[r] = 66'(r_s5_prod[3*r]) + 66'(r_s5_prod[3*r+1])
                     + 66'(r_s5_prod[3*r+2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (w_en) begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 3; r++) r_s6_acc[r] <= w_sum[r][65:20];
        end
    end

    // divider set-up: magnitudes scaled by the output fraction
    logic [NUM_W-1:0] w_mag_x, w_mag_y;
    logic             w_div_vld [DIV_STEPS+1];
    t_div_word        w_div     [DIV_STEPS+1];
    logic             r_s7_vld;
    t_div_word        r_s7;

    assign w_mag_x = r_s6_acc[0][NUM_W-1] ? NUM_W'(-r_s6_acc[0]) : NUM_W'(r_s6_acc[0]);
    assign w_mag_y = r_s6_acc[1][NUM_W-1] ? NUM_W'(-r_s6_acc[1]) : NUM_W'(r_s6_acc[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else if (w_en) begin
            r_s7_vld <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7.rem_x <= REM_W'(w_mag_x) << OUT_FRAC_BITS;
            r_s7.rem_y <= REM_W'(w_mag_y) << OUT_FRAC_BITS;
            r_s7.q_x   <= '0;
            r_s7.q_y   <= '0;
            r_s7.den   <= r_s6_acc[2][DEN_W-1:0];
            r_s7.neg_x <= r_s6_acc[0][NUM_W-1];
            r_s7.neg_y <= r_s6_acc[1][NUM_W-1];
            r_s7.front <= !r_s6_acc[2][NUM_W-1] && (|r_s6_acc[2]);
        end
    end

    assign w_div_vld[0] = r_s7_vld;
    assign w_div[0]     = r_s7;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        sbm_div_cell #(.SHIFT(DIV_STEPS - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_div_vld[g]),
            .i_w     (w_div[g]),
            .o_vld   (w_div_vld[g+1]),
            .o_w     (w_div[g+1])
        );
    end

    // saturate and sign; the top quotient bit flags overflow
    t_div_word w_dq;
    t_res      w_res;
    logic      w_clip_x, w_clip_y;
    logic signed [23:0] w_x, w_y;

    assign w_dq = w_div[DIV_STEPS];

    always_comb begin
        w_clip_x = 1'b0;
        w_clip_y = 1'b0;
        if (!w_dq.neg_x) begin
            if (w_dq.q_x[24] || w_dq.q_x[23:0] > 24'(OUT_MAX)) begin
                w_clip_x = 1'b1;
                w_x = OUT_MAX;
            end else begin
                w_x = $signed(w_dq.q_x[23:0]);
            end
        end else begin
            if (w_dq.q_x[24] || w_dq.q_x[23:0] > 24'h800000) begin
                w_clip_x = 1'b1;
                w_x = OUT_MIN;
            end else begin
                w_x = -$signed(w_dq.q_x[23:0]);
            end
        end
        if (!w_dq.neg_y) begin
            if (w_dq.q_y[24] || w_dq.q_y[23:0] > 24'(OUT_MAX)) begin
                w_clip_y = 1'b1;
                w_y = OUT_MAX;
            end else begin
                w_y = $signed(w_dq.q_y[23:0]);
            end
        end else begin
            if (w_dq.q_y[24] || w_dq.q_y[23:0] > 24'h800000) begin
                w_clip_y = 1'b1;
                w_y = OUT_MIN;
            end else begin
                w_y = -$signed(w_dq.q_y[23:0]);
            end
        end
        if (w_dq.front) begin
            w_res.src_x    = w_x;
            w_res.src_y    = w_y;
            w_res.in_front = 1'b1;
            w_res.clipped  = w_clip_x | w_clip_y;
        end else begin
            w_res.src_x    = BEHIND;
            w_res.src_y    = BEHIND;
            w_res.in_front = 1'b0;
            w_res.clipped  = 1'b0;
        end
    end

    // output register with skid entry
    logic r_m_vld;
    t_res r_m, r_sk;
    logic w_take;

    assign w_take = r_m_vld && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld  <= 1'b0;
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (w_take) begin
                r_sk_vld <= 1'b0;
            end
        end else if (w_div_vld[DIV_STEPS]) begin
            if (r_m_vld && !w_take) begin
                r_sk_vld <= 1'b1;
            end else begin
                r_m_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_vld) begin
            if (w_take) begin
                r_m <= r_sk;
            end
        end else if (w_div_vld[DIV_STEPS]) begin
            if (r_m_vld && !w_take) begin
                r_sk <= w_res;
            end else begin
                r_m <= w_res;
            end
        end
    end

    assign o_out.valid    = r_m_vld;
    assign o_out.src_x    = r_m.src_x;
    assign o_out.src_y    = r_m.src_y;
    assign o_out.in_front = r_m.in_front;
    assign o_out.clipped  = r_m.clipped;
endmodule
